// ----- hdl/ci32alu_pkg.sv -----
package ci32alu_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_POW = 4'd5,
      OP_NEG = 4'd6,
      OP_EQ  = 4'd7,
      OP_NE  = 4'd8,
      OP_LT  = 4'd9,
      OP_GT  = 4'd10,
      OP_LE  = 4'd11,
      OP_GE  = 4'd12,
      OP_AND = 4'd13,
      OP_OR  = 4'd14
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_DIV_ZERO = 2'd2,
      STAT_NEG_EXP  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MULT,
      S_DIV,
      S_DONE
   } state_type;

endpackage

// ----- hdl/checked_int32_alu.sv -----
// Overflow-checked signed 32-bit ALU.
// Request channel: req_tuser carries the operation code, req_tdata the two operands.
// Response channel: rsp_tdata carries the value, rsp_tuser the status (0 ok,
// 1 overflow, 2 divide by zero, 3 negative exponent); the value is 0 on any error.
// Add, subtract, negate, compares and logic ops are worked out in the cycle of the transfer;
// the result goes to a result register and then to the output register once it is free.
// Multiply runs a shift-add loop, one multiplier bit per cycle over the significant
// bits of |right_operand|.
// Divide and remainder run a restoring divider, one quotient bit per cycle.
// Power repeats the shift-add multiply, each partial product stepping over the bits
// of |left_operand|; the loop stops at the first partial product that leaves the
// 32-bit range, so the longest run is base -2 with exponent 32 or more.
// One item is worked on at a time. When the receiver stalls, the finished result
// waits in the output register while the block takes and finishes one more item,
// which then holds until the output register frees up.
// Reset is synchronous and clears the sequencer and the output valid; no clearing pass.
module checked_int32_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*ci32alu_pkg::DATA_W-1:0]     req_tdata,  // right_operand (upper half), left_operand (lower half)
   input  logic [3:0]                           req_tuser,  // operation
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ci32alu_pkg::DATA_W-1:0]       rsp_tdata,  // value
   output logic [1:0]                           rsp_tuser   // status
);
   import ci32alu_pkg::*;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [DATA_W:0]       acc_ff, acc_in;      // product accumulator / partial remainder
   logic                  big_ff, big_in;      // product already out of range
   logic [DATA_W:0]       mc_ff, mc_in;        // shifted multiplicand / divisor
   logic                  mcbig_ff, mcbig_in;  // multiplicand shifted past the top
   logic [DATA_W-1:0]     mp_ff, mp_in;        // multiplier / dividend-quotient shifter
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  bneg_ff, bneg_in;
   logic [DATA_W-1:0]     pb_ff, pb_in;
   logic [DATA_W-2:0]     exp_ff, exp_in;
   logic [DATA_W-1:0]     res_val_ff, res_val_in;
   status_type            res_st_ff, res_st_in;
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_val_ff;
   status_type            rsp_st_ff;

   logic [DATA_W-1:0]     a, b, abs_a, abs_b;
   op_type                op_req;
   logic                  accept, out_free, load_out;
   logic                  start_mult, start_div;
   logic [DATA_W:0]       x33, y33, sum33;
   logic                  do_sub, sum_ovf, lt, eq;
   logic [DATA_W-1:0]     quick_val;
   status_type            quick_st;
   logic [DATA_W+1:0]     madd;
   logic [DATA_W:0]       mstep_acc;
   logic                  mstep_big, mul_last, mul_fits, pow_more;
   logic [DATA_W-1:0]     mul_signed;
   logic [DATA_W:0]       dsh, dstep_rem;
   logic [DATA_W+1:0]     ddiff;
   logic                  dge, div_last, div_fits;
   logic [DATA_W-1:0]     dstep_quo, quo_signed, rem_signed;

   assign a      = req_tdata[DATA_W-1:0];
   assign b      = req_tdata[2*DATA_W-1:DATA_W];
   assign op_req = op_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign abs_a  = a[DATA_W-1] ? (~a + 1'b1) : a;
   assign abs_b  = b[DATA_W-1] ? (~b + 1'b1) : b;

   assign start_mult = (op_req == OP_MUL && b != '0) ||
                       (op_req == OP_POW && !b[DATA_W-1] && b != '0 &&
                        abs_a[DATA_W-1:1] != '0);
   assign start_div  = (op_req == OP_DIV || op_req == OP_MOD) && b != '0;

   // single adder shared by add, sub, neg and the less/greater compares
   assign x33     = (op_req == OP_NEG) ? '0 : {a[DATA_W-1], a};
   assign y33     = (op_req == OP_NEG) ? {a[DATA_W-1], a} : {b[DATA_W-1], b};
   assign do_sub  = (op_req != OP_ADD);
   assign sum33   = x33 + (do_sub ? ~y33 : y33) + (DATA_W+1)'(do_sub);
   assign sum_ovf = sum33[DATA_W] ^ sum33[DATA_W-1];
   assign lt      = sum33[DATA_W];
   assign eq      = (a == b);

   always_comb begin
      quick_val = '0;
      quick_st  = STAT_OK;
      unique case (op_req)
         OP_ADD, OP_SUB, OP_NEG: begin
            if (sum_ovf) quick_st = STAT_OVERFLOW;
            else         quick_val = sum33[DATA_W-1:0];
         end
         OP_MUL: quick_val = '0;
         OP_DIV, OP_MOD: quick_st = STAT_DIV_ZERO;
         OP_POW: begin
            if (b[DATA_W-1])          quick_st = STAT_NEG_EXP;
            else if (b == '0)         quick_val = DATA_W'(1);
            else if (abs_a == '0)     quick_val = '0;
            else if (a[DATA_W-1] && b[0]) quick_val = '1;
            else                      quick_val = DATA_W'(1);
         end
         OP_EQ:  quick_val = DATA_W'(eq);
         OP_NE:  quick_val = DATA_W'(!eq);
         OP_LT:  quick_val = DATA_W'(lt);
         OP_GT:  quick_val = DATA_W'(!lt && !eq);
         OP_LE:  quick_val = DATA_W'(lt || eq);
         OP_GE:  quick_val = DATA_W'(!lt);
         OP_AND: quick_val = DATA_W'(a != '0 && b != '0);
         OP_OR:  quick_val = DATA_W'(a != '0 || b != '0);
         default: quick_val = '0;
      endcase
   end

   // shift-add multiply step on magnitudes
   assign madd       = {1'b0, acc_ff} + {1'b0, mc_ff};
   assign mstep_acc  = (mp_ff[0] && !mcbig_ff) ? madd[DATA_W:0] : acc_ff;
   assign mstep_big  = big_ff | (mp_ff[0] & (mcbig_ff | madd[DATA_W+1]));
   assign mul_last   = (mp_ff[DATA_W-1:1] == '0);
   // negative results may reach magnitude 2^31
   assign mul_fits   = !mstep_big && !mstep_acc[DATA_W] &&
                       (!mstep_acc[DATA_W-1] || (neg_ff && mstep_acc[DATA_W-2:0] == '0));
   assign mul_signed = neg_ff ? (~mstep_acc[DATA_W-1:0] + 1'b1) : mstep_acc[DATA_W-1:0];
   assign pow_more   = (op_ff == OP_POW) && mul_fits && (exp_ff != (DATA_W-1)'(1));

   // restoring divide step
   assign dsh        = {acc_ff[DATA_W-1:0], mp_ff[DATA_W-1]};
   assign ddiff      = {1'b0, dsh} - {2'b00, mc_ff[DATA_W-1:0]};
   assign dge        = !ddiff[DATA_W+1];
   assign dstep_rem  = dge ? ddiff[DATA_W:0] : dsh;
   assign dstep_quo  = {mp_ff[DATA_W-2:0], dge};
   assign div_last   = (cnt_ff == '0);
   // only the most negative value over minus one gives a quotient of 2^31
   assign div_fits   = neg_ff || !dstep_quo[DATA_W-1];
   assign quo_signed = neg_ff ? (~dstep_quo + 1'b1) : dstep_quo;
   assign rem_signed = neg_ff ? (~dstep_rem[DATA_W-1:0] + 1'b1) : dstep_rem[DATA_W-1:0];

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      out_free   = !rsp_valid_ff || rsp_tready;
      load_out   = (state_ff == S_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (start_mult)     state_in = S_MULT;
               else if (start_div) state_in = S_DIV;
               else                state_in = S_DONE;
            end
         end
         S_MULT: if (mul_last && !pow_more) state_in = S_DONE;
         S_DIV:  if (div_last) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in      = op_ff;
      acc_in     = acc_ff;
      big_in     = big_ff;
      mc_in      = mc_ff;
      mcbig_in   = mcbig_ff;
      mp_in      = mp_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      bneg_in    = bneg_ff;
      pb_in      = pb_ff;
      exp_in     = exp_ff;
      res_val_in = res_val_ff;
      res_st_in  = res_st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = op_req;
               acc_in     = '0;
               big_in     = 1'b0;
               mcbig_in   = 1'b0;
               cnt_in     = CNT_W'(DATA_W - 1);
               res_val_in = quick_val;
               res_st_in  = quick_st;
               unique case (op_req)
                  OP_MUL: begin
                     mc_in  = {1'b0, abs_a};
                     mp_in  = abs_b;
                     neg_in = a[DATA_W-1] ^ b[DATA_W-1];
                  end
                  OP_DIV, OP_MOD: begin
                     mc_in  = {1'b0, abs_b};
                     mp_in  = abs_a;
                     neg_in = (op_req == OP_DIV) ? (a[DATA_W-1] ^ b[DATA_W-1]) : a[DATA_W-1];
                  end
                  OP_POW: begin
                     // first partial product is 1 * |base|
                     mc_in   = (DATA_W+1)'(1);
                     mp_in   = abs_a;
                     pb_in   = abs_a;
                     bneg_in = a[DATA_W-1];
                     neg_in  = a[DATA_W-1];
                     exp_in  = b[DATA_W-2:0];
                  end
                  default: ;
               endcase
            end
         end
         S_MULT: begin
            acc_in   = mstep_acc;
            big_in   = mstep_big;
            mc_in    = {mc_ff[DATA_W-1:0], 1'b0};
            mcbig_in = mcbig_ff | mc_ff[DATA_W];
            mp_in    = mp_ff >> 1;
            if (mul_last) begin
               if (pow_more) begin
                  acc_in   = '0;
                  big_in   = 1'b0;
                  mc_in    = {1'b0, mstep_acc[DATA_W-1:0]};
                  mcbig_in = 1'b0;
                  mp_in    = pb_ff;
                  neg_in   = neg_ff ^ bneg_ff;
                  exp_in   = exp_ff - 1'b1;
               end else begin
                  res_val_in = mul_fits ? mul_signed : '0;
                  res_st_in  = mul_fits ? STAT_OK : STAT_OVERFLOW;
               end
            end
         end
         S_DIV: begin
            acc_in = dstep_rem;
            mp_in  = dstep_quo;
            cnt_in = cnt_ff - 1'b1;
            if (div_last) begin
               if (op_ff == OP_DIV) begin
                  res_val_in = div_fits ? quo_signed : '0;
                  res_st_in  = div_fits ? STAT_OK : STAT_OVERFLOW;
               end else begin
                  res_val_in = rem_signed;
                  res_st_in  = STAT_OK;
               end
            end
         end
         S_DONE: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      acc_ff     <= acc_in;
      big_ff     <= big_in;
      mc_ff      <= mc_in;
      mcbig_ff   <= mcbig_in;
      mp_ff      <= mp_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      bneg_ff    <= bneg_in;
      pb_ff      <= pb_in;
      exp_ff     <= exp_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      if (load_out) begin
         rsp_val_ff <= res_val_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_st_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tdata == '0))
      else $error("error response with nonzero value");

   a_mult_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MULT) |-> (mp_ff != '0))
      else $error("multiply loop running with empty multiplier");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != '0) |=> (state_ff == S_DIV))
      else $error("divider left before all quotient bits");

endmodule
